FILE: sv/asc_pkg.sv
// shared types, constants and scale lookup for the accelerometer scale and calibrate block
`timescale 1ns / 1ps
package asc_pkg;

  localparam int unsigned RAW_W    = 8;
  localparam int unsigned SAMPLE_W = 13;  // 12-bit sample plus room for negating z
  localparam int unsigned FACTOR_W = 13;
  localparam int unsigned SCALED_W = 24;
  localparam int unsigned COEF_W   = 16;
  localparam int unsigned PROD_W   = SCALED_W + COEF_W;
  localparam int unsigned ACC_W    = PROD_W + 2;
  localparam int unsigned OUT_W    = 32;
  localparam int unsigned REG_W    = 48;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned CAL_SHIFT    = 18;
  localparam int unsigned RAW_SHIFT    = 4;
  localparam int unsigned OFFSET_SHIFT = 20;
  localparam int unsigned NUM_AXES     = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_FULL_SCALE   = 3'd0,
    REG_CAL_ENABLE   = 3'd1,
    REG_WEIGHTS_X    = 3'd2,
    REG_WEIGHTS_Y    = 3'd3,
    REG_WEIGHTS_Z    = 3'd4,
    REG_OFFSETS      = 3'd5
  } cfg_idx_t;

  typedef logic [NUM_AXES-1:0][SCALED_W-1:0] scaled_vec_t;
  typedef logic [NUM_AXES-1:0][COEF_W-1:0]   coef_vec_t;

  typedef struct packed {
    logic en2;
    logic en3;
    logic cal_en;
  } axis_ctl_t;

  // scale factor in 2^-20 g per lsb; the unused code uses the 3.9 mg factor
  function automatic logic [FACTOR_W-1:0] scale_of(input logic [1:0] fs);
    logic [FACTOR_W-1:0] f;
    case (fs)
      2'd0:    f = 13'd1049;
      2'd1:    f = 13'd2097;
      default: f = 13'd4089;
    endcase
    return f;
  endfunction

endpackage

FILE: sv/asc_axis.sv
// one output axis: weight products, then sum with offset, shift and bypass select
`timescale 1ns / 1ps
module asc_axis import asc_pkg::*; (
  input  logic                clk,
  input  axis_ctl_t           ctl,
  input  scaled_vec_t         v,       // scaled x, y, z
  input  logic [SCALED_W-1:0] v_self,  // this axis' scaled value for bypass
  input  coef_vec_t           w,       // weights of x, y, z for this axis
  input  logic [COEF_W-1:0]   off,
  output logic [OUT_W-1:0]    accel
);

  logic [NUM_AXES-1:0][PROD_W-1:0] prod_r, prod_nxt;
  logic [PROD_W-5:0]               off_r, off_nxt;   // offset times 2^20, 36 bits
  logic [SCALED_W-5:0]             byp_r, byp_nxt;
  logic [OUT_W-1:0]                accel_r, accel_nxt;
  logic signed [ACC_W-1:0]         acc;
  logic [ACC_W-CAL_SHIFT-1:0]      cal_val;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      prod_nxt[i] = PROD_W'($signed(v[i]) * $signed(w[i]));
    end
    off_nxt = {off, {OFFSET_SHIFT{1'b0}}};
    byp_nxt = v_self[SCALED_W-1:RAW_SHIFT];
  end

  always_comb begin
    acc = ACC_W'($signed(prod_r[0])) + ACC_W'($signed(prod_r[1]))
        + ACC_W'($signed(prod_r[2])) + ACC_W'($signed(off_r));
    // floor shift; the 24-bit result always fits in 32 bits, no clipping left
    cal_val = acc[ACC_W-1:CAL_SHIFT];
    if (ctl.cal_en) begin
      accel_nxt = OUT_W'($signed(cal_val));
    end else begin
      accel_nxt = OUT_W'($signed(byp_r));
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en2) begin
      prod_r <= prod_nxt;
      off_r  <= off_nxt;
      byp_r  <= byp_nxt;
    end
    if (ctl.en3) begin
      accel_r <= accel_nxt;
    end
  end

  assign accel = accel_r;

endmodule

FILE: sv/accel_sample_scale_calibrate_core.sv
// top level: config registers, sample scaling stage and three calibrated output axes
// pipeline: out_tvalid rises once an accepted request has passed the scale, products and sum registers
// throughput: one request per cycle unless the output stalls; three register stages with valid bits, stall-safe
// in_tready is low only when all three stages hold requests and the output is stalled
// reset (rst_n low, synchronous) empties the pipeline and sets full_scale to 3.9 mg,
// calibration off and the identity matrix with zero offsets
`timescale 1ns / 1ps
module accel_sample_scale_calibrate_core import asc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // x_low_byte, x_high_byte, y_low_byte, y_high_byte, z_low_byte, z_high_byte
  input  logic [6*RAW_W-1:0]         in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // accel_x, accel_y, accel_z
  output logic [NUM_AXES*OUT_W-1:0]  out_tdata,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [IDX_W-1:0]           cfg_index,
  input  logic [REG_W-1:0]           cfg_data
);

  logic [1:0]       full_scale_r;
  logic             cal_en_r;
  logic [REG_W-1:0] wx_r, wy_r, wz_r, off_r;

  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;
  scaled_vec_t scaled_r, scaled_nxt;
  axis_ctl_t ctl;
  logic [NUM_AXES-1:0][OUT_W-1:0] accel;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_scale_r <= 2'd2;
      cal_en_r     <= 1'b0;
      wx_r         <= 48'd16384;
      wy_r         <= 48'd1073741824;
      wz_r         <= 48'd70368744177664;
      off_r        <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        REG_FULL_SCALE: full_scale_r <= cfg_data[1:0];
        REG_CAL_ENABLE: cal_en_r     <= cfg_data[0];
        REG_WEIGHTS_X:  wx_r         <= cfg_data;
        REG_WEIGHTS_Y:  wy_r         <= cfg_data;
        REG_WEIGHTS_Z:  wz_r         <= cfg_data;
        REG_OFFSETS:    off_r        <= cfg_data;
        default: ;
      endcase
    end
  end

  // stall chain: a stage moves when the one after it is empty or moving
  assign en3       = !v3_r || out_tready;
  assign en2       = !v2_r || en3;
  assign en1       = !v1_r || en2;
  assign in_tready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_tvalid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  // stage 1: word >>> 4 is the top 12 bits; z is negated before scaling
  always_comb begin
    logic [FACTOR_W-1:0] fac;
    logic [SAMPLE_W-1:0] smp;
    fac = scale_of(full_scale_r);
    for (int i = 0; i < NUM_AXES; i++) begin
      smp = SAMPLE_W'($signed(in_tdata[16*i+RAW_SHIFT +: 16-RAW_SHIFT]));
      if (i == NUM_AXES-1) begin
        smp = SAMPLE_W'(-$signed(smp));
      end
      scaled_nxt[i] = SCALED_W'($signed(smp) * $signed({1'b0, fac}));
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      scaled_r <= scaled_nxt;
    end
  end

  assign ctl = '{en2: en2, en3: en3, cal_en: cal_en_r};

  for (genvar j = 0; j < NUM_AXES; j++) begin : g_axis
    asc_axis u_axis (
      .clk    (clk),
      .ctl    (ctl),
      .v      (scaled_r),
      .v_self (scaled_r[j]),
      .w      ({wz_r[16*j +: 16], wy_r[16*j +: 16], wx_r[16*j +: 16]}),
      .off    (off_r[16*j +: 16]),
      .accel  (accel[j])
    );
  end

  assign out_tvalid = v3_r;
  assign out_tdata  = accel;

  a_full_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (v1_r && v2_r && v3_r))
    else $error("input stalled while a pipeline stage is empty");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> v1_r)
    else $error("accepted request did not enter stage 1");

  a_stage2_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && en3) |=> v3_r)
    else $error("stage 2 request lost on the way to the output");

  a_range_x: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (accel[0][OUT_W-1:SCALED_W-1] == '0 || accel[0][OUT_W-1:SCALED_W-1] == '1))
    else $error("accel_x beyond 24-bit range");

  a_range_z: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (accel[2][OUT_W-1:SCALED_W-1] == '0 || accel[2][OUT_W-1:SCALED_W-1] == '1))
    else $error("accel_z beyond 24-bit range");

endmodule
